>>> sv/adaptive_rans_literal_model_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the adaptive rANS symbol decoder
// Shared property forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_RANS_LITERAL_MODEL_DEFINES_SVH
`define ADAPTIVE_RANS_LITERAL_MODEL_DEFINES_SVH

// same-cycle implication
`define ARLM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arlm: same-cycle check failed");

// next-cycle implication
`define ARLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arlm: next-cycle check failed");

`endif

>>> sv/arlm_pkg.sv
// ---------------------------------------------------------------------------
// arlm_pkg
// Constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none
package arlm_pkg;

  localparam int NumSymbols  = 300;
  localparam int RampSymbols = 264;
  localparam int ProbBits    = 15;
  localparam int ProbTotal   = 32768;
  localparam int StepInc     = 31;
  localparam int AdaptBonus  = 725;
  localparam int AdaptPeriod = 1024;

  // ramp slope (ProbTotal - NumSymbols + RampSymbols) / RampSymbols as q + r/RampSymbols
  localparam int RampNum     = ProbTotal - NumSymbols + RampSymbols;
  localparam int RampQuot    = RampNum / RampSymbols;
  localparam int RampRem     = RampNum % RampSymbols;
  localparam int TailBase    = ProbTotal - NumSymbols;

  typedef struct packed {
    logic init_clr;
    logic init_step;
    logic load;
    logic s_rd;
    logic s_cmp;
    logic rd_hi;
    logic rd_lo;
    logic mul;
    logic fin;
    logic a_clr;
    logic a_rd;
    logic a_wr;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic adapt_now;
    logic init_last;
    logic adapt_last;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/arlm_ctrl.sv
// ---------------------------------------------------------------------------
// arlm_ctrl
// Sequencer: table init sweep, binary search, state update, adaptation pass.
// ---------------------------------------------------------------------------
`default_nettype none
module arlm_ctrl import arlm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SRD   = 4'd2;
  localparam logic [3:0] ST_SCMP  = 4'd3;
  localparam logic [3:0] ST_RDHI  = 4'd4;
  localparam logic [3:0] ST_RDLO  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_ARD   = 4'd8;
  localparam logic [3:0] ST_AWR   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SRD;
        end
      end
      ST_SRD: begin
        if (sts.search_done) begin
          state_next = ST_RDHI;
        end else begin
          cmd.s_rd   = 1'b1;
          state_next = ST_SCMP;
        end
      end
      ST_SCMP: begin
        cmd.s_cmp  = 1'b1;
        state_next = ST_SRD;
      end
      ST_RDHI: begin
        cmd.rd_hi  = 1'b1;
        state_next = ST_RDLO;
      end
      ST_RDLO: begin
        cmd.rd_lo  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (sts.adapt_now) begin
          cmd.a_clr  = 1'b1;
          state_next = ST_ARD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ARD: begin
        cmd.a_rd   = 1'b1;
        state_next = ST_AWR;
      end
      ST_AWR: begin
        cmd.a_wr   = 1'b1;
        state_next = sts.adapt_last ? ST_IDLE : ST_ARD;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
    if (rst) cmd.init_clr = 1'b1;
  end

endmodule
`default_nettype wire

>>> sv/arlm_dp.sv
// ---------------------------------------------------------------------------
// arlm_dp
// Datapath: bound and count memories, search bounds, state arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none
module arlm_dp import arlm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [31:0] rans_state,
  output logic             done,
  output logic [8:0]       symbol,
  output logic [31:0]      next_state
);

  logic [15:0] cum_mem [0:NumSymbols];
  logic [15:0] cnt_mem [0:NumSymbols-1];

  logic [31:0] st;
  logic [8:0]  lo;
  logic [8:0]  hi;
  logic [8:0]  idx;
  logic [14:0] q;
  logic [8:0]  r;
  logic [16:0] sum;
  logic [10:0] adapt_cnt;
  logic        adapt_now;
  logic [15:0] hiv;
  logic [15:0] lov;
  logic [31:0] prod;
  logic [15:0] cum_q;
  logic [15:0] cnt_q;

  logic [9:0]  mid_sum;
  logic [8:0]  mid;
  logic [8:0]  lo_m1;
  logic [8:0]  idx_p1;
  logic [10:0] adapt_dec;
  logic [9:0]  r_add;
  logic [15:0] init_val;
  logic [16:0] sum_n;
  logic signed [17:0] diff;
  logic signed [17:0] half;
  logic [15:0] new_cb;
  logic [15:0] width;
  logic [32:0] prod_full;
  logic [15:0] cnt_add;

  logic        cum_we;
  logic [8:0]  cum_wa;
  logic [15:0] cum_wd;
  logic [8:0]  cum_ra;
  logic        cnt_we;
  logic [8:0]  cnt_wa;
  logic [15:0] cnt_wd;
  logic [8:0]  cnt_ra;
  logic        rd_en;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[9:1];
  assign lo_m1     = lo - 9'd1;
  assign idx_p1    = idx + 9'd1;
  assign adapt_dec = adapt_cnt - 11'd1;
  assign r_add     = {1'b0, r} + 10'(RampRem);
  assign init_val  = (idx < 9'(RampSymbols)) ? {1'b0, q} : 16'(TailBase) + {7'b0, idx};
  assign sum_n     = sum + {1'b0, cnt_q};
  assign diff      = $signed({1'b0, sum_n}) - $signed({2'b0, cum_q});
  assign half      = diff >>> 1;
  assign new_cb    = cum_q + half[15:0];
  assign width     = hiv - cum_q;
  assign prod_full = {16'b0, st[31:15]} * {17'b0, width};
  assign cnt_add   = cnt_q + 16'(StepInc) + (adapt_now ? 16'(AdaptBonus) : 16'd0);
  assign rd_en     = cmd.s_rd | cmd.rd_hi | cmd.rd_lo | cmd.a_rd;

  assign sts.search_done = (lo == hi);
  assign sts.adapt_now   = adapt_now;
  assign sts.init_last   = (idx == 9'(NumSymbols));
  assign sts.adapt_last  = (idx == 9'(NumSymbols - 1));

  always_comb begin
    cum_we = 1'b0;
    cum_wa = idx;
    cum_wd = init_val;
    cnt_we = 1'b0;
    cnt_wa = idx;
    cnt_wd = 16'd1;
    if (cmd.init_step) begin
      cum_we = 1'b1;
      cnt_we = (idx < 9'(NumSymbols));
    end else if (cmd.a_wr) begin
      cum_we = 1'b1;
      cum_wa = idx_p1;
      cum_wd = new_cb;
      cnt_we = 1'b1;
    end else if (cmd.mul) begin
      cnt_we = 1'b1;
      cnt_wa = lo_m1;
      cnt_wd = cnt_add;
    end
    if (cmd.s_rd) begin
      cum_ra = mid;
    end else if (cmd.rd_hi) begin
      cum_ra = lo;
    end else if (cmd.rd_lo) begin
      cum_ra = lo_m1;
    end else begin
      cum_ra = idx_p1;
    end
    cnt_ra = cmd.rd_lo ? lo_m1 : idx;
  end

  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_wa] <= cum_wd;
    if (rd_en) cum_q <= cum_mem[cum_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (rd_en) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_clr) begin
      idx <= '0;
      q   <= '0;
      r   <= '0;
    end else if (cmd.init_step) begin
      idx <= idx_p1;
      if (r_add >= 10'(RampSymbols)) begin
        r <= 9'(r_add - 10'(RampSymbols));
        q <= q + 15'(RampQuot + 1);
      end else begin
        r <= r_add[8:0];
        q <= q + 15'(RampQuot);
      end
    end else if (cmd.a_clr) begin
      idx <= '0;
      sum <= '0;
    end else if (cmd.a_wr) begin
      idx <= idx_p1;
      sum <= sum_n;
    end
    if (cmd.load) begin
      st <= rans_state;
      lo <= 9'd1;
      hi <= 9'(NumSymbols);
    end else if (cmd.s_cmp) begin
      if ({1'b0, st[14:0]} < cum_q) begin
        hi <= mid;
      end else begin
        lo <= mid + 9'd1;
      end
    end
    if (cmd.rd_lo) hiv <= cum_q;
    if (cmd.mul) begin
      lov  <= cum_q;
      prod <= prod_full[31:0];
    end
    if (cmd.fin) begin
      symbol     <= lo_m1;
      next_state <= {17'b0, st[14:0]} + prod - {16'b0, lov};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_cnt <= 11'(AdaptPeriod);
      adapt_now <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.load) begin
        adapt_now <= (adapt_dec == 11'd0);
        adapt_cnt <= (adapt_dec == 11'd0) ? 11'(AdaptPeriod) : adapt_dec;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/adaptive_rans_literal_model.sv
// ---------------------------------------------------------------------------
// adaptive_rans_literal_model
// Adaptive rANS symbol decoder with a 301-entry cumulative frequency table.
// ---------------------------------------------------------------------------
// Usage:
//   Drive rans_state and raise start while busy is low; that beat is taken.
//   One result per beat: done pulses for one cycle with symbol and
//   next_state. The receiver cannot stall; results must be taken then.
//   Sequence: a binary search of 8 or 9 probes, each a table read (SRD)
//   and a compare (SCMP), a state leaving the search, then bound reads
//   (RDHI, RDLO), multiply (MUL) and output (FIN); done is registered from FIN.
//   The bound table is a single-port-read memory, which sets the probe rate.
//   Every 1024th decode adds an adaptation pass over the table, a read
//   (ARD) and a write (AWR) per entry, during which busy stays high.
//   After reset the block runs an init sweep over all 301 bounds, loading
//   the ramp bounds and unit counts; busy is high until it ends.
//   Unless an adaptation pass follows, busy drops in the cycle done is
//   high; a new beat is taken only once the previous one is through.
// ---------------------------------------------------------------------------
`default_nettype none
`include "adaptive_rans_literal_model_defines.svh"
module adaptive_rans_literal_model import arlm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] rans_state,
  output logic             done,
  output logic [8:0]       symbol,
  output logic [31:0]      next_state
);

  cmd_t cmd;
  sts_t sts;

  arlm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  arlm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .rans_state (rans_state),
    .done       (done),
    .symbol     (symbol),
    .next_state (next_state)
  );

  `ARLM_ASSERT_SAME(a_sym_range, done, symbol < 9'(NumSymbols))
  `ARLM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ARLM_ASSERT_NEXT(a_done_pulse, done, !done)
  `ARLM_ASSERT_SAME(a_search_bounds, sts.search_done, cmd.s_rd == 1'b0)

endmodule
`default_nettype wire

>>> tb/sv/arlm_checker.sv
// ---------------------------------------------------------------------------
// arlm_checker
// Watches the decode command and result channels, keeps its own copy of the
// adaptive cumulative table, predicts symbol and next state per beat and
// compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
module arlm_checker import arlm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] rans_state,
  input  logic        done,
  input  logic [8:0]  symbol,
  input  logic [31:0] next_state,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [8:0]  sym;
    logic [31:0] nxt;
  } decode_t;

  logic [15:0] bound [0:NumSymbols];
  logic [15:0] tally [0:NumSymbols-1];
  logic [10:0] until_adapt;
  decode_t     expected_q[$];

  function automatic decode_t decode_symbol(logic [31:0] st);
    decode_t     r;
    logic [31:0] m, lo, hi, sum, cb;
    int          s;
    m = st & 32'h7FFF;
    r.sym = 9'(NumSymbols - 1);
    for (s = 0; s < NumSymbols; s++) begin
      if (m < {16'd0, bound[s+1]}) begin
        r.sym = 9'(s);
        break;
      end
    end
    lo = {16'd0, bound[r.sym]};
    hi = {16'd0, bound[r.sym+1]};
    r.nxt = m + (st >> ProbBits) * (hi - lo) - lo;
    tally[r.sym] = tally[r.sym] + 16'(StepInc);
    until_adapt = until_adapt - 11'd1;
    if (until_adapt == 0) begin
      until_adapt = 11'(AdaptPeriod);
      tally[r.sym] = tally[r.sym] + 16'(AdaptBonus);
      sum = 0;
      for (s = 0; s < NumSymbols; s++) begin
        cb = {16'd0, bound[s+1]};
        sum = sum + {16'd0, tally[s]};
        tally[s] = 16'd1;
        bound[s+1] = 16'(cb + ((sum - cb) >> 1));
      end
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    decode_t e;
    if (rst) begin
      for (int i = 0; i <= NumSymbols; i++)
        bound[i] = (i < RampSymbols) ? 16'(RampNum * i / RampSymbols) : 16'(TailBase + i);
      for (int i = 0; i < NumSymbols; i++) tally[i] = 16'd1;
      until_adapt = 11'(AdaptPeriod);
      expected_q.delete();
      err_count <= 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: symbol %0d next_state %h",
                   $time, symbol, next_state);
          err_count <= err_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (symbol !== e.sym || next_state !== e.nxt) begin
            $display("%0t: mismatch: expected symbol %0d next_state %h, got %0d %h",
                     $time, e.sym, e.nxt, symbol, next_state);
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(decode_symbol(rans_state));
    end
  end

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives directed and random rANS states into the decoder with random gaps,
// past the first adaptation pass, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
  import arlm_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [31:0] rans_state = 0;
  logic        busy, done;
  logic [8:0]  symbol;
  logic [31:0] next_state;
  int          err_count, pending;
  int          cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  adaptive_rans_literal_model DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rans_state(rans_state),
    .done(done), .symbol(symbol), .next_state(next_state)
  );

  arlm_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rans_state(rans_state),
    .done(done), .symbol(symbol), .next_state(next_state),
    .err_count(err_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(logic [31:0] st);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    rans_state <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_state();
    logic [31:0] hi, lo;
    hi = $urandom;
    case ($urandom_range(0, 5))
      0: lo = $urandom_range(32468, 32767);
      1: lo = $urandom_range(0, 200);
      default: lo = $urandom_range(0, 32767);
    endcase
    if ($urandom_range(0, 7) == 0) hi = $urandom_range(0, 3) << 15;
    return {hi[31:15], lo[14:0]};
  endfunction

  initial begin
    logic [31:0] directed [0:9];
    directed = '{32'h0, 32'hFFFFFFFF, 32'h00007FFF, 32'hFFFF8000, 32'h00000001,
                 32'h12347F9B, 32'hAAAAAAAA, 32'h55555555, 32'h80007FD4, 32'h7FFF7E00};
    repeat (2) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_beat(directed[i]);
    for (int i = 0; i < 1150; i++) send_beat(pick_state());
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
